// ----- sv/occupancy_grid_block_downsampler_unit_assert.svh -----
// Assertion helpers shared by the checker.
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef OCCUPANCY_GRID_BLOCK_DOWNSAMPLER_UNIT_ASSERT_SVH
`define OCCUPANCY_GRID_BLOCK_DOWNSAMPLER_UNIT_ASSERT_SVH

// same-cycle implication
`define OGBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OGBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ogbd_pkg.sv -----
`default_nettype none
package ogbd_pkg;

  localparam int SIDE_REG_W = 5;
  localparam int DIM_REG_W  = 11;
  localparam int CELL_W     = 8;
  localparam int IDX_W      = 20;
  localparam int CLASS_W    = 2;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_SIDE   = 16;

  localparam logic [SIDE_REG_W-1:0] SIDE_RST = 5'd1;
  localparam logic [DIM_REG_W-1:0]  DIM_RST  = 11'd1024;

  localparam logic signed [CELL_W-1:0] CELL_OCC = 8'sd100;
  localparam logic signed [CELL_W-1:0] CELL_UNK = -8'sd1;

  localparam int OUTQ_DEPTH = 4;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_FREE = 2'd0,
    CLASS_OCC  = 2'd1,
    CLASS_UNK  = 2'd2
  } class_t;

  typedef enum logic [1:0] {
    REG_SIDE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // per-beat control from the scan counters to the accumulator
  typedef struct packed {
    logic first;
    logic emit;
    logic last;
  } scan_ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    class_t           cls;
    logic             last;
  } out_beat_t;

endpackage
`default_nettype wire

// ----- sv/occupancy_grid_block_downsampler_unit.sv -----
// Occupancy-grid block downsampler.
// Input channel (in_valid / in_stall / in_cell_value): one grid cell per beat,
// raster order. 100 is occupied, -1 unknown, anything else free.
// Output channel (out_valid / out_stall / out_block_*): one beat per finished
// block, carrying its row-major index, class (0 free, 1 occupied, 2 unknown)
// and a flag on the last block of the map.
// Throughput: one cell per cycle while in_stall is low. Per-block-column counts
// live in a one-port read / one-port write memory; a cell reads its entry on
// acceptance, adds and writes back the next cycle, with the write data forwarded
// to a back-to-back cell on the same column. A finished block's counts pass a
// class register and then the output queue, which shows the beat.
// A four-beat output queue decouples the sides; in_stall rises only when the
// queue plus results still in flight would fill it, so a stalled receiver
// backs up into the input after a few beats.
// Reset: registers to block_side 1, map 1024 x 1024, scan at the first cell, queue empty.
// No memory clearing pass: a block's first cell zeroes its entry. An APB register write to side,
// width or height restarts the scan; the user writes only while idle, which the block does not enforce.
`default_nettype none
module occupancy_grid_block_downsampler_unit #(
  parameter int MAX_WIDTH  = ogbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ogbd_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_SIDE   = ogbd_pkg::DEF_MAX_SIDE
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ogbd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ogbd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ogbd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ogbd_pkg::CELL_W-1:0] in_cell_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ogbd_pkg::IDX_W-1:0]         out_block_index,
  output logic [ogbd_pkg::CLASS_W-1:0]       out_block_class,
  output logic                               out_last_block
);
  import ogbd_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CNT_W = $clog2(MAX_SIDE * MAX_SIDE + 1);

  logic [SIDE_REG_W-1:0] side_eff;
  logic [DIM_REG_W-1:0]  width_eff, height_eff;
  logic                  restart;
  logic                  accept;
  scan_ctl_t             ctl;
  logic [COL_W-1:0]      col_addr;
  logic [IDX_W-1:0]      index;
  logic                  res_v, res_last;
  logic [CNT_W-1:0]      res_total, res_occ, res_unk;
  logic [IDX_W-1:0]      res_index;
  logic                  q_busy;

  assign in_stall = q_busy;
  assign accept   = in_valid & ~in_stall;

  ogbd_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_SIDE  (MAX_SIDE)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .side_eff  (side_eff),
    .width_eff (width_eff),
    .height_eff(height_eff),
    .restart   (restart)
  );

  ogbd_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_SIDE  (MAX_SIDE)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .accept    (accept),
    .side_eff  (side_eff),
    .width_eff (width_eff),
    .height_eff(height_eff),
    .ctl       (ctl),
    .col_addr  (col_addr),
    .index     (index)
  );

  ogbd_accum #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_SIDE (MAX_SIDE)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .ctl       (ctl),
    .col_addr  (col_addr),
    .index     (index),
    .cell_value(in_cell_value),
    .res_v     (res_v),
    .res_total (res_total),
    .res_occ   (res_occ),
    .res_unk   (res_unk),
    .res_index (res_index),
    .res_last  (res_last)
  );

  ogbd_outq #(
    .MAX_SIDE(MAX_SIDE)
  ) u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_v          (res_v),
    .res_total      (res_total),
    .res_occ        (res_occ),
    .res_unk        (res_unk),
    .res_index      (res_index),
    .res_last       (res_last),
    .q_busy         (q_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_block_index(out_block_index),
    .out_block_class(out_block_class),
    .out_last_block (out_last_block)
  );

endmodule
`default_nettype wire

// ----- sv/ogbd_cfg.sv -----
`default_nettype none
module ogbd_cfg #(
  parameter int MAX_WIDTH  = ogbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ogbd_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_SIDE   = ogbd_pkg::DEF_MAX_SIDE
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ogbd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ogbd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ogbd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [ogbd_pkg::SIDE_REG_W-1:0]   side_eff,
  output logic [ogbd_pkg::DIM_REG_W-1:0]    width_eff,
  output logic [ogbd_pkg::DIM_REG_W-1:0]    height_eff,
  output logic                              restart
);
  import ogbd_pkg::*;

  logic [SIDE_REG_W-1:0] side_r, side_nxt;
  logic [DIM_REG_W-1:0]  width_r, width_nxt;
  logic [DIM_REG_W-1:0]  height_r, height_nxt;
  logic                  wr;
  reg_idx_t              idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_comb begin
    side_nxt   = side_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    restart    = 1'b0;
    prdata     = '0;
    unique case (idx)
      REG_SIDE: begin
        prdata = APB_DATA_W'(side_r);
        if (wr) begin
          side_nxt = pwdata[SIDE_REG_W-1:0];
          restart  = 1'b1;
        end
      end
      REG_WIDTH: begin
        prdata = APB_DATA_W'(width_r);
        if (wr) begin
          width_nxt = pwdata[DIM_REG_W-1:0];
          restart   = 1'b1;
        end
      end
      REG_HEIGHT: begin
        prdata = APB_DATA_W'(height_r);
        if (wr) begin
          height_nxt = pwdata[DIM_REG_W-1:0];
          restart    = 1'b1;
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r   <= SIDE_RST;
      width_r  <= DIM_RST;
      height_r <= DIM_RST;
    end else begin
      side_r   <= side_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // zero reads as one, oversize saturates to the build limit
  always_comb begin
    if (side_r == '0)
      side_eff = SIDE_REG_W'(1);
    else if (32'(side_r) > MAX_SIDE)
      side_eff = SIDE_REG_W'(MAX_SIDE);
    else
      side_eff = side_r;

    if (width_r == '0)
      width_eff = DIM_REG_W'(1);
    else if (32'(width_r) > MAX_WIDTH)
      width_eff = DIM_REG_W'(MAX_WIDTH);
    else
      width_eff = width_r;

    if (height_r == '0)
      height_eff = DIM_REG_W'(1);
    else if (32'(height_r) > MAX_HEIGHT)
      height_eff = DIM_REG_W'(MAX_HEIGHT);
    else
      height_eff = height_r;
  end

endmodule
`default_nettype wire

// ----- sv/ogbd_scan.sv -----
`default_nettype none
module ogbd_scan #(
  parameter int MAX_WIDTH  = ogbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ogbd_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_SIDE   = ogbd_pkg::DEF_MAX_SIDE,
  localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            restart,
  input  logic                            accept,
  input  logic [ogbd_pkg::SIDE_REG_W-1:0] side_eff,
  input  logic [ogbd_pkg::DIM_REG_W-1:0]  width_eff,
  input  logic [ogbd_pkg::DIM_REG_W-1:0]  height_eff,
  output ogbd_pkg::scan_ctl_t             ctl,
  output logic [COL_W-1:0]                col_addr,
  output logic [ogbd_pkg::IDX_W-1:0]      index
);
  import ogbd_pkg::*;

  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int OFF_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int MAX_CW = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CMP_W  = ((MAX_CW > DIM_REG_W) ? MAX_CW : DIM_REG_W) + 1;

  logic [COL_W-1:0] cell_col_r, cell_col_nxt;
  logic [ROW_W-1:0] cell_row_r, cell_row_nxt;
  logic [OFF_W-1:0] off_col_r, off_col_nxt;
  logic [OFF_W-1:0] off_row_r, off_row_nxt;
  logic [COL_W-1:0] blk_col_r, blk_col_nxt;
  logic [IDX_W-1:0] row_base_r, row_base_nxt;   // index of first block in this block row

  logic col_last, row_last, side_col_end, side_row_end;

  assign col_last     = (CMP_W'(cell_col_r) + CMP_W'(1)) >= CMP_W'(width_eff);
  assign row_last     = (CMP_W'(cell_row_r) + CMP_W'(1)) >= CMP_W'(height_eff);
  assign side_col_end = (CMP_W'(off_col_r) + CMP_W'(1)) >= CMP_W'(side_eff);
  assign side_row_end = (CMP_W'(off_row_r) + CMP_W'(1)) >= CMP_W'(side_eff);

  assign ctl.first = (off_row_r == '0) && (off_col_r == '0);
  assign ctl.emit  = (side_row_end | row_last) & (side_col_end | col_last);
  assign ctl.last  = row_last & col_last;
  assign col_addr  = blk_col_r;
  assign index     = row_base_r + IDX_W'(blk_col_r);

  always_comb begin
    cell_col_nxt = cell_col_r;
    cell_row_nxt = cell_row_r;
    off_col_nxt  = off_col_r;
    off_row_nxt  = off_row_r;
    blk_col_nxt  = blk_col_r;
    row_base_nxt = row_base_r;
    if (col_last) begin
      cell_col_nxt = '0;
      off_col_nxt  = '0;
      blk_col_nxt  = '0;
      if (row_last) begin
        cell_row_nxt = '0;
        off_row_nxt  = '0;
        row_base_nxt = '0;
      end else begin
        cell_row_nxt = cell_row_r + ROW_W'(1);
        if (side_row_end) begin
          off_row_nxt  = '0;
          // blocks in a row = last block column + 1
          row_base_nxt = row_base_r + IDX_W'(blk_col_r) + IDX_W'(1);
        end else begin
          off_row_nxt = off_row_r + OFF_W'(1);
        end
      end
    end else begin
      cell_col_nxt = cell_col_r + COL_W'(1);
      if (side_col_end) begin
        off_col_nxt = '0;
        blk_col_nxt = blk_col_r + COL_W'(1);
      end else begin
        off_col_nxt = off_col_r + OFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      cell_col_r <= '0;
      cell_row_r <= '0;
      off_col_r  <= '0;
      off_row_r  <= '0;
      blk_col_r  <= '0;
      row_base_r <= '0;
    end else if (accept) begin
      cell_col_r <= cell_col_nxt;
      cell_row_r <= cell_row_nxt;
      off_col_r  <= off_col_nxt;
      off_row_r  <= off_row_nxt;
      blk_col_r  <= blk_col_nxt;
      row_base_r <= row_base_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ogbd_accum.sv -----
`default_nettype none
module ogbd_accum #(
  parameter int MAX_WIDTH = ogbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SIDE  = ogbd_pkg::DEF_MAX_SIDE,
  localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int CNT_W    = $clog2(MAX_SIDE * MAX_SIDE + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  ogbd_pkg::scan_ctl_t               ctl,
  input  logic [COL_W-1:0]                  col_addr,
  input  logic [ogbd_pkg::IDX_W-1:0]        index,
  input  logic signed [ogbd_pkg::CELL_W-1:0] cell_value,
  output logic                              res_v,
  output logic [CNT_W-1:0]                  res_total,
  output logic [CNT_W-1:0]                  res_occ,
  output logic [CNT_W-1:0]                  res_unk,
  output logic [ogbd_pkg::IDX_W-1:0]        res_index,
  output logic                              res_last
);
  import ogbd_pkg::*;

  localparam int WORD_W = 3 * CNT_W;

  // one entry per block column: {total, occupied, unknown}
  logic [WORD_W-1:0] mem [MAX_WIDTH];
  logic [WORD_W-1:0] rd_data_r;

  logic              s1_v_r;
  scan_ctl_t         s1_ctl_r;
  logic [COL_W-1:0]  s1_addr_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              s1_occ_r, s1_unk_r;

  logic              wb_v_r;
  logic [COL_W-1:0]  wb_addr_r;
  logic [WORD_W-1:0] wb_data_r;

  logic [WORD_W-1:0] base_word, new_word;
  logic [CNT_W-1:0]  base_tot, base_occ, base_unk;

  always_ff @(posedge clk) begin
    if (s1_v_r)
      mem[s1_addr_r] <= new_word;
    if (accept)
      rd_data_r <= mem[col_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      wb_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      wb_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r  <= ctl;
      s1_addr_r <= col_addr;
      s1_idx_r  <= index;
      s1_occ_r  <= (cell_value == CELL_OCC);
      s1_unk_r  <= (cell_value == CELL_UNK);
    end
    if (s1_v_r) begin
      wb_addr_r <= s1_addr_r;
      wb_data_r <= new_word;
    end
  end

  // read and write of the same column on one edge: take the write data
  always_comb begin
    if (s1_ctl_r.first)
      base_word = '0;
    else if (wb_v_r && (wb_addr_r == s1_addr_r))
      base_word = wb_data_r;
    else
      base_word = rd_data_r;
  end

  assign {base_tot, base_occ, base_unk} = base_word;
  assign new_word = {base_tot + CNT_W'(1),
                     base_occ + CNT_W'(s1_occ_r),
                     base_unk + CNT_W'(s1_unk_r)};

  assign res_v     = s1_v_r & s1_ctl_r.emit;
  assign {res_total, res_occ, res_unk} = new_word;
  assign res_index = s1_idx_r;
  assign res_last  = s1_ctl_r.last;

endmodule
`default_nettype wire

// ----- sv/ogbd_outq.sv -----
`default_nettype none
module ogbd_outq #(
  parameter int MAX_SIDE = ogbd_pkg::DEF_MAX_SIDE,
  localparam int CNT_W   = $clog2(MAX_SIDE * MAX_SIDE + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             res_v,
  input  logic [CNT_W-1:0]                 res_total,
  input  logic [CNT_W-1:0]                 res_occ,
  input  logic [CNT_W-1:0]                 res_unk,
  input  logic [ogbd_pkg::IDX_W-1:0]       res_index,
  input  logic                             res_last,
  output logic                             q_busy,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ogbd_pkg::IDX_W-1:0]       out_block_index,
  output logic [ogbd_pkg::CLASS_W-1:0]     out_block_class,
  output logic                             out_last_block
);
  import ogbd_pkg::*;

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OCC_W = CNT_W + 5;
  localparam int UNK_W = CNT_W + 3;

  logic             s2_v_r;
  logic [CNT_W-1:0] s2_tot_r, s2_occ_r, s2_unk_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic             s2_last_r;

  logic [CNT_W-1:0] known;
  class_t           cls;
  out_beat_t        beat;

  out_beat_t        q_r [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n)
      s2_v_r <= 1'b0;
    else
      s2_v_r <= res_v;
  end

  always_ff @(posedge clk) begin
    if (res_v) begin
      s2_tot_r  <= res_total;
      s2_occ_r  <= res_occ;
      s2_unk_r  <= res_unk;
      s2_idx_r  <= res_index;
      s2_last_r <= res_last;
    end
  end

  // occupied: known > 0 and 20*occ >= known; unknown: 5*unk >= 2*total or nothing known
  assign known = s2_tot_r - s2_unk_r;

  always_comb begin
    if ((known != '0) && ((OCC_W'(s2_occ_r) * OCC_W'(20)) >= OCC_W'(known)))
      cls = CLASS_OCC;
    else if ((known == '0) ||
             ((UNK_W'(s2_unk_r) * UNK_W'(5)) >= UNK_W'({s2_tot_r, 1'b0})))
      cls = CLASS_UNK;
    else
      cls = CLASS_FREE;
  end

  assign beat.index = s2_idx_r;
  assign beat.cls   = cls;
  assign beat.last  = s2_last_r;

  assign push = s2_v_r;
  assign pop  = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (push)
      q_r[wr_ptr_r] <= beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push)
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      cnt_r <= cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  // reserve a slot for every result still in the pipe
  assign q_busy = ((PTR_W+2)'(cnt_r) + (PTR_W+2)'(res_v) + (PTR_W+2)'(s2_v_r))
                  >= (PTR_W+2)'(OUTQ_DEPTH);

  assign out_valid       = (cnt_r != '0);
  assign out_block_index = q_r[rd_ptr_r].index;
  assign out_block_class = q_r[rd_ptr_r].cls;
  assign out_last_block  = q_r[rd_ptr_r].last;

endmodule
`default_nettype wire

// ----- sv/ogbd_checker.sv -----
`default_nettype none
`include "occupancy_grid_block_downsampler_unit_assert.svh"
module ogbd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         psel,
  input logic                         penable,
  input logic                         pready,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ogbd_pkg::IDX_W-1:0]   out_block_index,
  input logic [ogbd_pkg::CLASS_W-1:0] out_block_class,
  input logic                         out_last_block
);
  import ogbd_pkg::*;

  logic                   in_take;
  logic                   take_d1_r, take_d2_r;
  logic                   out_wait, drained;
  logic [IDX_W+CLASS_W:0] out_beat;

  assign in_take  = in_valid & ~in_stall;
  assign out_wait = out_valid & out_stall;
  assign out_beat = {out_block_index, out_block_class, out_last_block};
  // nothing taken per take_d1_r and take_d2_r, and queue empty: pipe is drained
  assign drained  = ~out_valid & ~take_d1_r & ~take_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      take_d1_r <= 1'b1;
      take_d2_r <= 1'b1;
    end else begin
      take_d1_r <= in_take;
      take_d2_r <= take_d1_r;
    end
  end

  // stalled output beat holds
  `OGBD_ASSERT_NXT(a_out_hold, out_wait, out_valid && $stable(out_beat), "stalled beat changed")

  `OGBD_ASSERT_IMP(a_cls_code, out_valid, out_block_class <= CLASS_UNK, "undefined block class")

  `OGBD_ASSERT_IMP(a_apb_ready, psel && penable, pready, "APB access not ready")

  `OGBD_ASSERT_IMP(a_idle_no_stall, drained, !in_stall, "input stalled while block is empty")

endmodule

bind occupancy_grid_block_downsampler_unit ogbd_checker u_ogbd_checker (.*);
`default_nettype wire

// ----- test/ogbd_block_checker.sv -----
`timescale 1ns / 100ps
module ogbd_block_checker #(
  parameter int MAX_W = ogbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_H = ogbd_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_S = ogbd_pkg::DEF_MAX_SIDE
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ogbd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ogbd_pkg::APB_DATA_W-1:0]    pwdata,
  input  logic                               pready,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [ogbd_pkg::CELL_W-1:0] in_cell_value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [ogbd_pkg::IDX_W-1:0]         out_block_index,
  input  logic [ogbd_pkg::CLASS_W-1:0]       out_block_class,
  input  logic                               out_last_block,
  output int                                 mismatches = 0,
  output int                                 pending = 0,
  output int                                 blocks_seen = 0
);
  import ogbd_pkg::*;

  localparam int CNT_W = 9;

  logic [SIDE_REG_W-1:0] side_reg;
  logic [DIM_REG_W-1:0]  width_reg;
  logic [DIM_REG_W-1:0]  height_reg;

  int unsigned cell_col, cell_row, off_col, off_row, blk_col, blk_row;

  // running counts per block column
  logic [CNT_W-1:0] tot_cnt [MAX_W];
  logic [CNT_W-1:0] occ_cnt [MAX_W];
  logic [CNT_W-1:0] unk_cnt [MAX_W];

  out_beat_t expected_blocks[$];
  int bad = 0;
  int n_checked = 0;

  function automatic int unsigned fit(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic class_t grade(int unsigned tot, int unsigned occ, int unsigned unk);
    int unsigned known;
    known = tot - unk;
    if (known != 0 && 20 * occ >= known) return CLASS_OCC;
    if (known == 0 || 5 * unk >= 2 * tot) return CLASS_UNK;
    return CLASS_FREE;
  endfunction

  task automatic restart_scan();
    cell_col = 0;
    cell_row = 0;
    off_col  = 0;
    off_row  = 0;
    blk_col  = 0;
    blk_row  = 0;
  endtask

  task automatic take_cell(input logic signed [CELL_W-1:0] v);
    int unsigned side, w, h, bc;
    logic row_end, col_end;
    out_beat_t blk;
    side = fit(side_reg, MAX_S);
    w    = fit(width_reg, MAX_W);
    h    = fit(height_reg, MAX_H);
    bc   = blk_col % MAX_W;
    // first cell of a block zeroes its column entry
    if (off_row == 0 && off_col == 0) begin
      tot_cnt[bc] = '0;
      occ_cnt[bc] = '0;
      unk_cnt[bc] = '0;
    end
    tot_cnt[bc] = tot_cnt[bc] + 1'b1;
    if (v == CELL_OCC) occ_cnt[bc] = occ_cnt[bc] + 1'b1;
    if (v == CELL_UNK) unk_cnt[bc] = unk_cnt[bc] + 1'b1;

    row_end = (off_row + 1 >= side) || (cell_row + 1 >= h);
    col_end = (off_col + 1 >= side) || (cell_col + 1 >= w);
    if (row_end && col_end) begin
      blk.index = IDX_W'(blk_row * ((w + side - 1) / side) + blk_col);
      blk.cls   = grade(tot_cnt[bc], occ_cnt[bc], unk_cnt[bc]);
      blk.last  = (cell_row + 1 >= h) && (cell_col + 1 >= w);
      expected_blocks = {expected_blocks, blk};
    end

    if (cell_col + 1 >= w) begin
      cell_col = 0;
      off_col  = 0;
      blk_col  = 0;
      if (cell_row + 1 >= h) begin
        cell_row = 0;
        off_row  = 0;
        blk_row  = 0;
      end else begin
        cell_row++;
        if (off_row + 1 >= side) begin
          off_row = 0;
          blk_row++;
        end else begin
          off_row++;
        end
      end
    end else begin
      cell_col++;
      if (off_col + 1 >= side) begin
        off_col = 0;
        blk_col++;
      end else begin
        off_col++;
      end
    end
  endtask

  task automatic check_block();
    out_beat_t want;
    n_checked++;
    if (expected_blocks.size() == 0) begin
      bad++;
      if (bad <= 10)
        $display("checker: block beat with none expected: index %0d class %0d last %0d",
                 out_block_index, out_block_class, out_last_block);
    end else begin
      want = expected_blocks.pop_front();
      if (out_block_index !== want.index || out_block_class !== want.cls ||
          out_last_block !== want.last) begin
        bad++;
        if (bad <= 10)
          $display("checker: block mismatch: expected index %0d class %0d last %0d, %s",
                   want.index, want.cls, want.last,
                   $sformatf("got index %0d class %0d last %0d",
                             out_block_index, out_block_class, out_last_block));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      side_reg   = SIDE_RST;
      width_reg  = DIM_RST;
      height_reg = DIM_RST;
      restart_scan();
      expected_blocks.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        // any known register restarts the scan; other addresses are dropped
        case (paddr[APB_ADDR_W-1:2])
          REG_SIDE: begin
            side_reg = pwdata[SIDE_REG_W-1:0];
            restart_scan();
          end
          REG_WIDTH: begin
            width_reg = pwdata[DIM_REG_W-1:0];
            restart_scan();
          end
          REG_HEIGHT: begin
            height_reg = pwdata[DIM_REG_W-1:0];
            restart_scan();
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_block();
      if (in_valid && !in_stall) take_cell(in_cell_value);
    end
    pending     <= expected_blocks.size();
    mismatches  <= bad;
    blocks_seen <= n_checked;
  end

endmodule

// ----- test/tb_occupancy_grid_block_downsampler_unit.sv -----
`timescale 1ns / 100ps
module tb_occupancy_grid_block_downsampler_unit;
  import ogbd_pkg::*;

  localparam int unsigned BAD_REG_IDX    = 3;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int unsigned RAND_CELLS     = 300;

  logic clk;
  logic rst_n = 1'b0;

  logic                    psel    = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr   = '0;
  logic [APB_DATA_W-1:0]   pwdata  = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  logic                    in_valid      = 1'b0;
  logic                    in_stall;
  logic signed [CELL_W-1:0] in_cell_value = '0;
  logic                    out_valid;
  logic                    out_stall     = 1'b0;
  logic [IDX_W-1:0]        out_block_index;
  logic [CLASS_W-1:0]      out_block_class;
  logic                    out_last_block;

  int mismatches, pending, blocks_seen;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet     = 0;
  int unsigned cells_sent  = 0;
  int unsigned writes_done = 0;

  occupancy_grid_block_downsampler_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_block_index(out_block_index),
    .out_block_class(out_block_class),
    .out_last_block (out_last_block)
  );

  ogbd_block_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_block_index(out_block_index),
    .out_block_class(out_block_class),
    .out_last_block (out_last_block),
    .mismatches     (mismatches),
    .pending        (pending),
    .blocks_seen    (blocks_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb_occupancy_grid_block_downsampler_unit NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(input int unsigned idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    writes_done++;
    @(posedge clk);
  endtask

  task automatic send_cell(input logic signed [CELL_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cell_value <= v;
    do @(posedge clk); while (in_stall);
    cells_sent++;
  endtask

  // drain every expected block, then give a cell with no result time to retire
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mix(input int unsigned phase);
    case (phase % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 68; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 68; end
      default: begin idle_pct = 23; stall_pct = 23; end
    endcase
  endtask

  function automatic int unsigned dim_of(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic signed [CELL_W-1:0] pick_cell(int unsigned p_occ, int unsigned p_unk);
    int unsigned r;
    r = $urandom_range(99);
    if (r < p_occ) return CELL_OCC;
    if (r < p_occ + p_unk) return CELL_UNK;
    if ($urandom_range(9) == 0) return CELL_W'($urandom());
    return CELL_W'($urandom_range(0, 99));
  endfunction

  task automatic write_masked(input int unsigned idx, input int unsigned val, input int w);
    logic [APB_DATA_W-1:0] data;
    data = APB_DATA_W'(val);
    // junk above the field must be dropped by the register
    if ($urandom_range(3) == 0) data = data | ($urandom() << w);
    write_reg(idx, data);
  endtask

  initial begin
    int unsigned side_raw, w_raw, h_raw, n_cells, rand_cells, map_no, p_occ, p_unk, r;
    rand_cells = 0;
    map_no     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting, side 1: each cell is a block of its own
    set_mix(0);
    send_cell(CELL_OCC);
    send_cell(CELL_UNK);
    send_cell(8'sd0);
    send_cell(8'sd127);
    send_cell(-8'sd128);
    send_cell(8'sd99);
    send_cell(8'sd101);
    send_cell(-8'sd2);
    settle();

    // zero registers act as 1: every cell is a whole map
    write_reg(REG_SIDE, 0);
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 0);
    send_cell(CELL_OCC);
    send_cell(CELL_UNK);
    send_cell(8'sd5);
    settle();

    // 3x3 map in 2x2 blocks, partial on the right and bottom;
    // the unmapped write mid-map must not restart the scan
    write_reg(REG_SIDE, 2);
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    send_cell(CELL_UNK);
    send_cell(CELL_UNK);
    send_cell(CELL_OCC);
    settle();
    write_reg(BAD_REG_IDX, 32'hFFFF_FFFF);
    send_cell(CELL_UNK);
    send_cell(CELL_UNK);
    send_cell(8'sd0);
    send_cell(CELL_OCC);
    send_cell(8'sd0);
    send_cell(CELL_UNK);
    settle();

    // saturated width and side: one band of 64 blocks, last flag on the 1024th column
    set_mix(3);
    write_reg(REG_SIDE, 31);
    write_reg(REG_WIDTH, 2047);
    write_reg(REG_HEIGHT, 1);
    repeat (1024) send_cell(pick_cell(3, 20));
    settle();

    while (rand_cells < RAND_CELLS) begin
      set_mix(map_no);
      r = $urandom_range(99);
      if (r < 8)       side_raw = 0;
      else if (r < 16) side_raw = $urandom_range(17, 31);
      else if (r < 70) side_raw = $urandom_range(1, 4);
      else             side_raw = $urandom_range(5, 16);
      r = $urandom_range(99);
      if (r < 5)       w_raw = 0;
      else if (r < 12) w_raw = $urandom_range(25, 40);
      else             w_raw = $urandom_range(1, 24);
      h_raw = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 10);
      write_masked(REG_SIDE, side_raw, SIDE_REG_W);
      write_masked(REG_WIDTH, w_raw, DIM_REG_W);
      write_masked(REG_HEIGHT, h_raw, DIM_REG_W);

      case ($urandom_range(3))
        0: p_occ = 0;
        1: p_occ = 3;
        2: p_occ = 10;
        default: p_occ = 50;
      endcase
      case ($urandom_range(3))
        0: p_unk = 0;
        1: p_unk = 15;
        2: p_unk = 40;
        default: p_unk = 90;
      endcase

      n_cells = dim_of(w_raw, DEF_MAX_WIDTH) * dim_of(h_raw, DEF_MAX_HEIGHT);
      // some maps run twice back to back, some are cut short by the next write
      if ($urandom_range(99) < 15) n_cells = $urandom_range(1, n_cells);
      else                         n_cells = n_cells * $urandom_range(1, 2);
      repeat (n_cells) send_cell(pick_cell(p_occ, p_unk));
      settle();
      rand_cells += n_cells;
      map_no++;
    end

    $display("run: %0d cells, %0d register writes, %0d block beats checked",
             cells_sent, writes_done, blocks_seen);
    $display("run: zero, saturated and partial-edge maps; free, sender, receiver and both idle");
    if (mismatches == 0 && pending == 0) begin
      $display("tb_occupancy_grid_block_downsampler_unit OK");
    end else begin
      $display("tb_occupancy_grid_block_downsampler_unit NOT OK");
    end
    $finish;
  end

endmodule
